@@ design/vtpd_pkg.sv @@
// Shared constants, register codes and helpers for the vertex transform block.
package vtpd_pkg;

   localparam int COORD_W       = 32;
   localparam int PROD_W        = 64;
   localparam int SUM_W         = 68;
   localparam int QUO_W         = 32;
   localparam int CSR_W         = 64;
   localparam int REG_NUM       = 8;
   localparam int REG_IDX_W     = 3;
   localparam int DEF_FRAC_BITS = 16;

   localparam logic [REG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_ROW3_C01 = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_ROW3_C23 = 3'd7;

   localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

   typedef logic [CSR_W-1:0] csr_word_type;

   // identity matrix at reset
   function automatic csr_word_type csr_reset_value(input logic [REG_IDX_W-1:0] idx,
                                                    input int frac);
      csr_word_type one;
      csr_word_type res;
      one = csr_word_type'(1) << frac;
      case (idx)
         REG_ROW0_C01: res = one;
         REG_ROW1_C01: res = one << COORD_W;
         REG_ROW2_C23: res = one;
         REG_ROW3_C23: res = one << COORD_W;
         default:      res = '0;
      endcase
      return res;
   endfunction

endpackage

@@ design/vtpd_if.sv @@
// Request and response channel interfaces for the vertex transform block.
interface vtpd_req_if;
   import vtpd_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] px;
   logic [COORD_W-1:0] py;
   logic [COORD_W-1:0] pz;
   modport source (output valid, output px, output py, output pz, input ready);
   modport sink (input valid, input px, input py, input pz, output ready);
endinterface

interface vtpd_rsp_if;
   import vtpd_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] qx;
   logic [COORD_W-1:0] qy;
   logic [COORD_W-1:0] qz;
   logic               w_was_zero;
   logic               saturated;
   modport source (output valid, output qx, output qy, output qz, output w_was_zero,
                   output saturated, input ready);
   modport sink (input valid, input qx, input qy, input qz, input w_was_zero,
                 input saturated, output ready);
endinterface

@@ design/vtpd_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with clamp and bypass.
module vtpd_div
   import vtpd_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               en,
   input  logic [SUM_W-1:0]   num_mag,
   input  logic [SUM_W-1:0]   den,
   input  logic               neg,
   input  logic               byp,
   input  logic [COORD_W-1:0] byp_val,
   input  logic               byp_sat,
   output logic [COORD_W-1:0] q,
   output logic               sat
);
   localparam int NW   = SUM_W + FRAC_BITS;
   localparam int HI_W = NW - QUO_W;

   logic [NW-1:0]      nfull;
   logic [HI_W-1:0]    nhi;
   logic               ovf_in;

   logic [SUM_W-1:0]   rem_ff  [QUO_W+1];
   logic [QUO_W-1:0]   nlo_ff  [QUO_W+1];
   logic [QUO_W-1:0]   quo_ff  [QUO_W+1];
   logic [SUM_W-1:0]   den_ff  [QUO_W+1];
   logic               neg_ff  [QUO_W+1];
   logic               ovf_ff  [QUO_W+1];
   logic               byp_ff  [QUO_W+1];
   logic [COORD_W-1:0] bval_ff [QUO_W+1];
   logic               bsat_ff [QUO_W+1];

   logic [COORD_W-1:0] q_in, q_ff;
   logic               sat_in, sat_ff;

   assign nfull  = {num_mag, FRAC_BITS'(0)};
   assign nhi    = nfull[NW-1:QUO_W];
   // quotient of 2^32 or more cannot fit
   assign ovf_in = SUM_W'(nhi) >= den;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= SUM_W'(nhi);
         nlo_ff[0]  <= nfull[QUO_W-1:0];
         quo_ff[0]  <= '0;
         den_ff[0]  <= den;
         neg_ff[0]  <= neg;
         ovf_ff[0]  <= ovf_in;
         byp_ff[0]  <= byp;
         bval_ff[0] <= byp_val;
         bsat_ff[0] <= byp_sat;
      end
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      logic [SUM_W:0] trial;
      logic [SUM_W:0] diff;
      logic           ge;
      assign trial = {rem_ff[k-1], nlo_ff[k-1][QUO_W-1]};
      assign diff  = trial - {1'b0, den_ff[k-1]};
      assign ge    = trial >= {1'b0, den_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            nlo_ff[k]  <= nlo_ff[k-1] << 1;
            quo_ff[k]  <= {quo_ff[k-1][QUO_W-2:0], ge};
            den_ff[k]  <= den_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            byp_ff[k]  <= byp_ff[k-1];
            bval_ff[k] <= bval_ff[k-1];
            bsat_ff[k] <= bsat_ff[k-1];
         end
      end
   end

   always_comb begin
      q_in   = quo_ff[QUO_W];
      sat_in = 1'b0;
      if (byp_ff[QUO_W]) begin
         q_in   = bval_ff[QUO_W];
         sat_in = bsat_ff[QUO_W];
      end else if (ovf_ff[QUO_W]) begin
         q_in   = neg_ff[QUO_W] ? COORD_MIN : COORD_MAX;
         sat_in = 1'b1;
      end else if (neg_ff[QUO_W]) begin
         if (quo_ff[QUO_W] > COORD_MIN) begin
            q_in   = COORD_MIN;
            sat_in = 1'b1;
         end else begin
            q_in = -quo_ff[QUO_W];
         end
      end else if (quo_ff[QUO_W] > COORD_MAX) begin
         q_in   = COORD_MAX;
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff   <= q_in;
         sat_ff <= sat_in;
      end
   end

   assign q   = q_ff;
   assign sat = sat_ff;

endmodule

@@ design/vertex_transform_perspective_divide_top.sv @@
// Top level: matrix registers, multiply and sum stages, and three divider lanes.
// Usage:
//  req_if carries one point (px, py, pz, signed fixed point) per request;
//  rsp_if returns (qx, qy, qz, w_was_zero, saturated) for each request in order.
//  The point is taken as (x, y, z, 1) and multiplied by the 4x4 matrix held in
//  eight 64-bit registers written through csr_wr_en / csr_index / csr_wdata.
//  Write registers only while no request is in flight.
// Timing:
//  Stage 1 holds the twelve 32x32 products, stage 2 the four row sums, stage 3
//  magnitudes and the w == 0 path, then each lane runs a 32-stage restoring
//  divider (one quotient bit per stage, plus an entry stage) and an output
//  register. Throughput is one request per cycle unless the output stalls.
// Reset: synchronous, clears all pipeline valid bits and loads the identity matrix.
// Stall: when rsp_if.ready is low with a result waiting, the whole pipeline
//  holds and req_if.ready drops in the same cycle; nothing is lost or repeated.
module vertex_transform_perspective_divide_top
   import vtpd_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   vtpd_req_if.sink             req_if,
   vtpd_rsp_if.source           rsp_if,
   input  logic                 csr_wr_en,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);
   localparam int VLD_N = QUO_W + 5;
   localparam int WZ_N  = VLD_N - 2;

   csr_word_type              csr_ff [REG_NUM];
   logic signed [COORD_W-1:0] ent    [4][4];
   logic signed [COORD_W-1:0] pt     [3];

   logic signed [PROD_W-1:0]  prod_ff [4][3];
   logic signed [COORD_W-1:0] e3_ff   [4];
   logic signed [SUM_W-1:0]   sum_ff  [4];

   logic [SUM_W-1:0]   nmag_ff [3];
   logic [SUM_W-1:0]   den_ff;
   logic               neg_ff  [3];
   logic [COORD_W-1:0] bval_ff [3];
   logic               bsat_ff [3];

   logic               vld_ff [VLD_N];
   logic               wz_ff  [WZ_N];
   logic               en;
   logic               wz_in;

   logic [COORD_W-1:0] qv  [3];
   logic               sat [3];

   assign en            = !vld_ff[VLD_N-1] || rsp_if.ready;
   assign req_if.ready  = en;

   always_ff @(posedge clock) begin
      for (int i = 0; i < REG_NUM; i++) begin
         if (reset) begin
            csr_ff[i] <= csr_reset_value(REG_IDX_W'(i), FRAC_BITS);
         end else if (csr_wr_en && csr_index == REG_IDX_W'(i)) begin
            csr_ff[i] <= csr_wdata;
         end
      end
   end

   for (genvar r = 0; r < 4; r++) begin : g_row
      for (genvar c = 0; c < 4; c++) begin : g_col
         assign ent[r][c] = csr_ff[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
      end
   end

   assign pt[0] = req_if.px;
   assign pt[1] = req_if.py;
   assign pt[2] = req_if.pz;

   // stage 1: products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            e3_ff[r] <= ent[r][3];
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= PROD_W'(ent[r][c]) * PROD_W'(pt[c]);
            end
         end
      end
   end

   // stage 2: row sums, full precision
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            sum_ff[r] <= (SUM_W'(e3_ff[r]) <<< FRAC_BITS) + SUM_W'(prod_ff[r][0])
                         + SUM_W'(prod_ff[r][1]) + SUM_W'(prod_ff[r][2]);
         end
      end
   end

   // stage 3: magnitudes, signs, and the undivided path
   assign wz_in = sum_ff[3] == '0;

   always_ff @(posedge clock) begin
      logic signed [SUM_W-1:0] sh;
      logic                    fits;
      if (en) begin
         den_ff <= sum_ff[3][SUM_W-1] ? -sum_ff[3] : sum_ff[3];
         for (int c = 0; c < 3; c++) begin
            sh   = sum_ff[c] >>> FRAC_BITS;
            fits = (sh[SUM_W-1:COORD_W-1] == '0) || (sh[SUM_W-1:COORD_W-1] == '1);
            nmag_ff[c] <= sum_ff[c][SUM_W-1] ? -sum_ff[c] : sum_ff[c];
            neg_ff[c]  <= sum_ff[c][SUM_W-1] ^ sum_ff[3][SUM_W-1];
            bsat_ff[c] <= !fits;
            if (fits) begin
               bval_ff[c] <= sh[COORD_W-1:0];
            end else begin
               bval_ff[c] <= sh[SUM_W-1] ? COORD_MIN : COORD_MAX;
            end
         end
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_lane
      vtpd_div #(
         .FRAC_BITS(FRAC_BITS)
      ) u_div (
         .clock   (clock),
         .en      (en),
         .num_mag (nmag_ff[c]),
         .den     (den_ff),
         .neg     (neg_ff[c]),
         .byp     (wz_ff[0]),
         .byp_val (bval_ff[c]),
         .byp_sat (bsat_ff[c]),
         .q       (qv[c]),
         .sat     (sat[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VLD_N; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_if.valid;
         for (int i = 1; i < VLD_N; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wz_ff[0] <= wz_in;
         for (int i = 1; i < WZ_N; i++) begin
            wz_ff[i] <= wz_ff[i-1];
         end
      end
   end

   assign rsp_if.valid      = vld_ff[VLD_N-1];
   assign rsp_if.qx         = qv[0];
   assign rsp_if.qy         = qv[1];
   assign rsp_if.qz         = qv[2];
   assign rsp_if.w_was_zero = wz_ff[WZ_N-1];
   assign rsp_if.saturated  = sat[0] | sat[1] | sat[2];

   a_ready_follows_output : assert property (@(posedge clock) disable iff (reset)
      req_if.ready == (!rsp_if.valid || rsp_if.ready))
      else $error("request ready does not follow output stall");

   a_accept_enters_pipe : assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> vld_ff[0])
      else $error("accepted request not in first stage");

   a_sat_at_bound : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.saturated) |->
         (rsp_if.qx == COORD_MAX || rsp_if.qx == COORD_MIN ||
          rsp_if.qy == COORD_MAX || rsp_if.qy == COORD_MIN ||
          rsp_if.qz == COORD_MAX || rsp_if.qz == COORD_MIN))
      else $error("saturated flag without a clamped coordinate");

endmodule
